// ----- hw/rtl/ppmsd_pkg.sv -----
package ppmsd_pkg;

    // Channel count default and result limit of one read-all run
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int MAX_RESULTS      = 8;

    // Channel index carried between controller and datapath (fits 16 channels)
    localparam int CH_IDX_W = 4;
    // Width of a read-all length and of the reported valid count
    localparam int LEN_W    = 4;

    // Input word kinds
    localparam logic [1:0] KIND_CAPTURE  = 2'd0;
    localparam logic [1:0] KIND_READ_ONE = 2'd1;
    localparam logic [1:0] KIND_SET_OVR  = 2'd2;
    localparam logic [1:0] KIND_READ_ALL = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANNELS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE      = 3'd4;

    // Configuration reset values
    localparam logic [15:0] COUNTER_TOP_RST    = 16'd40000;
    localparam logic [15:0] SYNC_THRESHOLD_RST = 16'd8000;
    localparam logic [3:0]  MIN_CHANNELS_RST   = 4'd5;
    localparam logic [15:0] MIN_PULSE_RST      = 16'd900;
    localparam logic [15:0] MAX_PULSE_RST      = 16'd2100;

    // Output register source select
    localparam logic [1:0] OUT_ONE   = 2'd0;
    localparam logic [1:0] OUT_OVR   = 2'd1;
    localparam logic [1:0] OUT_EMPTY = 2'd2;
    localparam logic [1:0] OUT_ALL   = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic                capture;
        logic                read_one;
        logic                set_ovr;
        logic                all_start;
        logic                out_load;
        logic [1:0]          out_sel;
        logic [CH_IDX_W-1:0] all_idx;
        logic                all_last;
    } ppmsd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [LEN_W-1:0] all_len;
    } ppmsd_stat_t;

endpackage

// ----- hw/rtl/ppmsd_if.sv -----
interface ppmsd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [15:0]        timestamp;
    logic [7:0]         channel;
    logic signed [15:0] override_value;
    logic [7:0]         count;

    modport source (output valid, kind, timestamp, channel, override_value, count,
                    input ready);
    modport sink   (input valid, kind, timestamp, channel, override_value, count,
                    output ready);
endinterface

interface ppmsd_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic        value_valid;
    logic [3:0]  valid_count;
    logic        accepted;
    logic        last;

    modport source (output valid, value, value_valid, valid_count, accepted, last,
                    input ready);
    modport sink   (input valid, value, value_valid, valid_count, accepted, last,
                    output ready);
endinterface

interface ppmsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ppmsd_ctrl.sv -----
module ppmsd_ctrl #(
    parameter int NUM_CHANNELS = ppmsd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_kind,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ppmsd_pkg::ppmsd_stat_t stat,
    output ppmsd_pkg::ppmsd_cmd_t  cmd
);

    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ALL  = 1'b1;

    logic                        state_reg, state_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [ppmsd_pkg::LEN_W-1:0] len_reg, len_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        slot_free;
    logic                        run_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign out_valid = out_valid_reg;
    assign run_last  = (ppmsd_pkg::LEN_W'(idx_reg) + ppmsd_pkg::LEN_W'(1)) == len_reg;

    // Decode accepted words and step through read-all runs
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_kind)
                        ppmsd_pkg::KIND_CAPTURE:
                        begin
                            cmd.capture = 1'b1;
                        end
                        ppmsd_pkg::KIND_READ_ONE:
                        begin
                            cmd.read_one   = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_sel    = ppmsd_pkg::OUT_ONE;
                            out_valid_next = 1'b1;
                        end
                        ppmsd_pkg::KIND_SET_OVR:
                        begin
                            cmd.set_ovr    = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_sel    = ppmsd_pkg::OUT_OVR;
                            out_valid_next = 1'b1;
                        end
                        ppmsd_pkg::KIND_READ_ALL:
                        begin
                            cmd.all_start = 1'b1;
                            if (stat.all_len == '0)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_sel    = ppmsd_pkg::OUT_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ALL;
                                idx_next   = '0;
                                len_next   = stat.all_len;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ALL:
            begin
                // Emit one channel per free output slot
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = ppmsd_pkg::OUT_ALL;
                    cmd.all_idx    = ppmsd_pkg::CH_IDX_W'(idx_reg);
                    cmd.all_last   = run_last;
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + IW'(1);
                    if (run_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/ppmsd_dp.sv -----
module ppmsd_dp #(
    parameter int NUM_CHANNELS = ppmsd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [15:0]                       timestamp,
    input  logic [7:0]                        channel,
    input  logic signed [15:0]                override_value,
    input  logic [7:0]                        count,
    input  logic                              cfg_valid,
    input  logic [ppmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data,
    output logic                              cfg_ready,
    input  ppmsd_pkg::ppmsd_cmd_t             cmd,
    output ppmsd_pkg::ppmsd_stat_t            stat,
    output logic [15:0]                       value,
    output logic                              value_valid,
    output logic [3:0]                        valid_count,
    output logic                              accepted,
    output logic                              last
);

    localparam int IW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW  = $clog2(NUM_CHANNELS + 1);
    localparam int LIM = (NUM_CHANNELS < ppmsd_pkg::MAX_RESULTS) ?
                         NUM_CHANNELS : ppmsd_pkg::MAX_RESULTS;

    // Configuration registers
    logic [15:0] top_reg;
    logic [15:0] sync_reg;
    logic [3:0]  minch_reg;
    logic [15:0] minp_reg;
    logic [15:0] maxp_reg;

    // Decoder state
    logic [15:0] prev_reg;
    logic [CW-1:0] slot_reg;
    logic [CW-1:0] pub_reg;
    logic [CW-1:0] vc_reg;
    logic [15:0] pulse_reg [NUM_CHANNELS];
    logic [14:0] ovr_reg   [NUM_CHANNELS];

    // Output word
    logic [15:0] value_reg;
    logic        vv_reg;
    logic [3:0]  vcnt_reg;
    logic        acc_reg;
    logic        last_reg;

    logic [15:0]   gap;
    logic          is_sync;
    logic          slot_full;
    logic          ch_ok;
    logic          ovr_ok;
    logic          ovr_nonzero;
    logic [IW-1:0] rd_idx;
    logic [15:0]   half;
    logic [15:0]   clamped;
    logic [14:0]   rd_ovr;
    logic [15:0]   scaled;

    assign cfg_ready = 1'b1;

    // Pulse width from two captures, corrected for counter wrap
    assign gap       = timestamp - prev_reg + ((timestamp < prev_reg) ? top_reg : 16'd0);
    assign is_sync   = gap > sync_reg;
    assign slot_full = slot_reg == CW'(NUM_CHANNELS);

    assign ch_ok       = channel < 8'(NUM_CHANNELS);
    assign ovr_nonzero = override_value[14:0] != 15'd0;
    assign ovr_ok      = !override_value[15] && ch_ok;

    // Read-all length limited by channel count and run length
    assign stat.all_len = (count > 8'(LIM)) ? ppmsd_pkg::LEN_W'(LIM)
                                             : count[ppmsd_pkg::LEN_W-1:0];

    // Scale, clamp and override one stored width
    assign rd_idx = cmd.read_one ? channel[IW-1:0] : cmd.all_idx[IW-1:0];
    assign half   = {1'b0, pulse_reg[rd_idx][15:1]};
    assign rd_ovr = ovr_reg[rd_idx];

    always_comb
    begin
        if (half > maxp_reg)
        begin
            clamped = maxp_reg;
        end
        else if (half < minp_reg)
        begin
            clamped = minp_reg;
        end
        else
        begin
            clamped = half;
        end
        scaled = (rd_ovr != 15'd0) ? {1'b0, rd_ovr} : clamped;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= ppmsd_pkg::COUNTER_TOP_RST;
            sync_reg  <= ppmsd_pkg::SYNC_THRESHOLD_RST;
            minch_reg <= ppmsd_pkg::MIN_CHANNELS_RST;
            minp_reg  <= ppmsd_pkg::MIN_PULSE_RST;
            maxp_reg  <= ppmsd_pkg::MAX_PULSE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ppmsd_pkg::REG_COUNTER_TOP:    top_reg   <= cfg_data;
                ppmsd_pkg::REG_SYNC_THRESHOLD: sync_reg  <= cfg_data;
                ppmsd_pkg::REG_MIN_CHANNELS:   minch_reg <= cfg_data[3:0];
                ppmsd_pkg::REG_MIN_PULSE:      minp_reg  <= cfg_data;
                ppmsd_pkg::REG_MAX_PULSE:      maxp_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Frame decoding, slot stores and published count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            slot_reg <= '0;
            pub_reg  <= '0;
            vc_reg   <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                pulse_reg[i] <= '0;
                ovr_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.capture)
            begin
                prev_reg <= timestamp;
                if (is_sync)
                begin
                    if (8'(slot_reg) >= 8'(minch_reg))
                    begin
                        pub_reg <= slot_reg;
                    end
                    slot_reg <= '0;
                end
                else if (!slot_full)
                begin
                    pulse_reg[slot_reg[IW-1:0]] <= gap;
                    slot_reg <= slot_reg + CW'(1);
                    if (slot_reg == CW'(NUM_CHANNELS - 1))
                    begin
                        pub_reg <= CW'(NUM_CHANNELS);
                    end
                end
            end
            if (cmd.read_one && ch_ok)
            begin
                pub_reg <= '0;
            end
            if (cmd.all_start)
            begin
                vc_reg  <= pub_reg;
                pub_reg <= '0;
            end
            if (cmd.set_ovr && ovr_ok)
            begin
                ovr_reg[channel[IW-1:0]] <= override_value[14:0];
                if (ovr_nonzero)
                begin
                    pub_reg <= CW'(1);
                end
            end
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                ppmsd_pkg::OUT_ONE:
                begin
                    value_reg <= ch_ok ? scaled : 16'd0;
                    vv_reg    <= ch_ok;
                    vcnt_reg  <= 4'(pub_reg);
                    acc_reg   <= 1'b0;
                    last_reg  <= 1'b0;
                end
                ppmsd_pkg::OUT_OVR:
                begin
                    value_reg <= 16'd0;
                    vv_reg    <= 1'b0;
                    vcnt_reg  <= 4'd0;
                    acc_reg   <= ovr_ok && ovr_nonzero;
                    last_reg  <= 1'b0;
                end
                ppmsd_pkg::OUT_EMPTY:
                begin
                    value_reg <= 16'd0;
                    vv_reg    <= 1'b0;
                    vcnt_reg  <= 4'(pub_reg);
                    acc_reg   <= 1'b0;
                    last_reg  <= 1'b1;
                end
                default:
                begin
                    value_reg <= scaled;
                    vv_reg    <= 1'b1;
                    vcnt_reg  <= 4'(vc_reg);
                    acc_reg   <= 1'b0;
                    last_reg  <= cmd.all_last;
                end
            endcase
        end
    end

    assign value       = value_reg;
    assign value_valid = vv_reg;
    assign valid_count = vcnt_reg;
    assign accepted    = acc_reg;
    assign last        = last_reg;

endmodule

// ----- hw/rtl/ppm_sum_decoder_with_override.sv -----
// Channel | Role   | Word
// req     | sink   | capture edge, read one, set override or read all
// rsp     | source | one result word (value, value_valid, valid_count, accepted, last)
// cfg     | sink   | register index and 16-bit write data, always ready
//
// Capture edge: no result. Read one and set override: the
// result sits in the output register from the next cycle on.
// Read all of n channels: a start step, then one result per cycle while rsp is ready;
// the shared scale-and-clamp unit reads one stored channel per cycle.
// req stalls while a result is held unread and during a read-all run.
// Reset clears all stores and the published count at once.
module ppm_sum_decoder_with_override #(
    parameter int NUM_CHANNELS = ppmsd_pkg::NUM_CHANNELS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    ppmsd_req_if.sink   req,
    ppmsd_rsp_if.source rsp,
    ppmsd_cfg_if.sink   cfg
);

    ppmsd_pkg::ppmsd_cmd_t  cmd;
    ppmsd_pkg::ppmsd_stat_t stat;

    ppmsd_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_kind   (req.kind),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ppmsd_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .timestamp      (req.timestamp),
        .channel        (req.channel),
        .override_value (req.override_value),
        .count          (req.count),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .cfg_ready      (cfg.ready),
        .cmd            (cmd),
        .stat           (stat),
        .value          (rsp.value),
        .value_valid    (rsp.value_valid),
        .valid_count    (rsp.valid_count),
        .accepted       (rsp.accepted),
        .last           (rsp.last)
    );

`ifndef SYNTH
    // No new word while a result waits
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("input taken while a result is held");

    // Override results carry nothing but the accept flag
    a_ovr_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.accepted) |->
            (rsp.value == 16'd0 && !rsp.value_valid && !rsp.last && rsp.valid_count == 4'd0))
        else $error("override result carries reading fields");

    // A read-all start loads no result when a run follows
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.all_start && !cmd.out_load) |=> !req.ready)
        else $error("input taken during a read-all run");
`endif

endmodule
